@@ src/i2cbw_pkg.sv @@
// Package for the I2C bit-bang write sequencer.
// Holds the transfer structs, command codes, wait constants and the FSM state type.
// No dependencies.
`default_nettype none

package i2cbw_pkg;

    // Command codes carried in the action field.
    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_STOP  = 3'd1;
    localparam logic [2:0] ACT_BIT   = 3'd2;
    localparam logic [2:0] ACT_BYTE  = 3'd3;
    localparam logic [2:0] ACT_PULSE = 3'd4;

    // Bus timing in microseconds.
    localparam logic [15:0] SETUP_US    = 16'd10;
    localparam logic [15:0] HALF_BIT_US = 16'd5;

    // Phase and group limits of the fixed sequences.
    localparam int          PHASE_W       = 2;
    localparam int          GRP_W         = 5;
    localparam logic [1:0]  PH_LAST_THREE = 2'd2;
    localparam logic [1:0]  PH_LAST_FOUR  = 2'd3;
    localparam logic [4:0]  BYTE_GROUPS_M1 = 5'd8;

    // One input command.
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  data;
        logic [4:0]  pulse_count;
        logic [15:0] pulse_delay_ms;
    } t_in_item;

    // One line change as delivered to the consumer.
    typedef struct packed {
        logic        sda_level;
        logic        scl_level;
        logic [15:0] wait_amount;
        logic        wait_in_ms;
        logic        last_change;
    } t_out_item;

    // One decoded step: which pin moves, where to, and how long to hold.
    typedef struct packed {
        logic        is_scl;
        logic        level;
        logic [15:0] wait_amount;
        logic        wait_in_ms;
        logic        last_change;
    } t_change;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

endpackage

`default_nettype wire

@@ src/i2cbw_step_decode.sv @@
// Step decoder: maps the current command, phase and group to one line change.
// Depends on i2cbw_pkg.
`default_nettype none

module i2cbw_step_decode (
    input  wire logic [2:0]          i_action,
    input  wire logic [1:0]          i_phase,
    input  wire logic [4:0]          i_grp,
    input  wire logic [4:0]          i_grp_max,
    input  wire logic                i_bit,
    input  wire logic [15:0]         i_delay,
    output i2cbw_pkg::t_change       o_change,
    output logic [1:0]               o_phase_max
);

    // Pin, level and wait for each phase of each command.
    always_comb begin
        o_change    = '0;
        o_phase_max = i2cbw_pkg::PH_LAST_THREE;
        case (i_action)
            i2cbw_pkg::ACT_START: begin
                o_phase_max = i2cbw_pkg::PH_LAST_FOUR;
                case (i_phase)
                    2'd0: begin
                        o_change.is_scl = 1'b0;
                        o_change.level  = 1'b1;
                    end
                    2'd1: begin
                        o_change.is_scl      = 1'b1;
                        o_change.level       = 1'b1;
                        o_change.wait_amount = i2cbw_pkg::SETUP_US;
                    end
                    2'd2: begin
                        o_change.is_scl      = 1'b0;
                        o_change.level       = 1'b0;
                        o_change.wait_amount = i2cbw_pkg::SETUP_US;
                    end
                    default: begin
                        o_change.is_scl = 1'b1;
                        o_change.level  = 1'b0;
                    end
                endcase
            end
            i2cbw_pkg::ACT_STOP: begin
                case (i_phase)
                    2'd0: begin
                        o_change.is_scl      = 1'b0;
                        o_change.level       = 1'b0;
                        o_change.wait_amount = i2cbw_pkg::SETUP_US;
                    end
                    2'd1: begin
                        o_change.is_scl      = 1'b1;
                        o_change.level       = 1'b1;
                        o_change.wait_amount = i2cbw_pkg::SETUP_US;
                    end
                    default: begin
                        o_change.is_scl = 1'b0;
                        o_change.level  = 1'b1;
                    end
                endcase
            end
            i2cbw_pkg::ACT_BIT, i2cbw_pkg::ACT_BYTE: begin
                case (i_phase)
                    2'd0: begin
                        o_change.is_scl      = 1'b0;
                        o_change.level       = i_bit;
                        o_change.wait_amount = i2cbw_pkg::HALF_BIT_US;
                    end
                    2'd1: begin
                        o_change.is_scl      = 1'b1;
                        o_change.level       = 1'b1;
                        o_change.wait_amount = i2cbw_pkg::HALF_BIT_US;
                    end
                    default: begin
                        o_change.is_scl = 1'b1;
                        o_change.level  = 1'b0;
                    end
                endcase
            end
            i2cbw_pkg::ACT_PULSE: begin
                o_phase_max = i2cbw_pkg::PH_LAST_FOUR;
                // Both lines go high then low; the SCL changes carry the hold.
                o_change.is_scl = i_phase[0];
                o_change.level  = ~i_phase[1];
                if (i_phase[0]) begin
                    o_change.wait_amount = i_delay;
                    o_change.wait_in_ms  = 1'b1;
                end
            end
            default: begin
                o_change = '0;
            end
        endcase

        // The final change is the last phase of the last group.
        o_change.last_change = (i_phase == o_phase_max) && (i_grp == i_grp_max);
    end

endmodule

`default_nettype wire

@@ src/i2cbw_out_reg.sv @@
// Output register: tracks the driven levels of SDA and SCL and holds one result.
// Depends on i2cbw_pkg.
`default_nettype none

module i2cbw_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire i2cbw_pkg::t_change  i_change,
    input  wire logic                i_out_ready,
    output logic                     o_can_load,
    output logic                     o_out_valid,
    output i2cbw_pkg::t_out_item     o_out_data
);

    logic                 r_sda;
    logic                 r_scl;
    logic                 r_valid;
    i2cbw_pkg::t_out_item r_data;
    logic                 n_sda;
    logic                 n_scl;

    // Apply the change to the line that moves.
    always_comb begin
        n_sda = r_sda;
        n_scl = r_scl;
        if (i_change.is_scl) begin
            n_scl = i_change.level;
        end else begin
            n_sda = i_change.level;
        end
    end

    // Line state and valid flag; the lines idle high after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sda   <= 1'b1;
            r_scl   <= 1'b1;
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_sda   <= n_sda;
            r_scl   <= n_scl;
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data.sda_level   <= n_sda;
            r_data.scl_level   <= n_scl;
            r_data.wait_amount <= i_change.wait_amount;
            r_data.wait_in_ms  <= i_change.wait_in_ms;
            r_data.last_change <= i_change.last_change;
        end
    end

    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

@@ src/i2c_bitbang_write_sequencer_top.sv @@
// The first line change of a command passes the state register and then the output register
// before it is offered; then one change per cycle while the consumer takes them, stalling
// with it. A command is taken only when the sequencer is idle, so a new one waits until the
// last change of the current one is loaded; a byte write has 27 changes. Unknown actions and
// zero-count pulses produce no change. Reset is synchronous, active low; SDA, SCL start high.
// Depends on i2cbw_pkg, i2cbw_step_decode and i2cbw_out_reg.
`default_nettype none

module i2c_bitbang_write_sequencer_top #(
    parameter int MAX_PULSES = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire i2cbw_pkg::t_in_item  i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output i2cbw_pkg::t_out_item      o_out_item
);

    localparam logic [4:0] MaxPulsesW = 5'(MAX_PULSES);

    i2cbw_pkg::t_state  r_state;
    i2cbw_pkg::t_state  n_state;
    logic [2:0]         r_action;
    logic [15:0]        r_delay;
    logic [7:0]         r_shift;
    logic [1:0]         r_phase;
    logic [4:0]         r_grp;
    logic [4:0]         r_grp_max;

    logic               w_in_fire;
    logic               w_load;
    logic               w_can_load;
    logic               w_starts;
    logic [4:0]         w_count_sat;
    logic [4:0]         w_grp_max;
    logic [7:0]         w_shift;
    logic [1:0]         w_phase_max;
    i2cbw_pkg::t_change w_change;

    assign o_in_ready = (r_state == i2cbw_pkg::ST_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_load     = (r_state == i2cbw_pkg::ST_RUN) && w_can_load;

    // Decide whether a command produces changes, and set up its group limit and bits.
    always_comb begin
        w_count_sat = (i_in_item.pulse_count > MaxPulsesW) ? MaxPulsesW
                                                           : i_in_item.pulse_count;
        w_starts  = 1'b1;
        w_grp_max = '0;
        w_shift   = i_in_item.data;
        case (i_in_item.action)
            i2cbw_pkg::ACT_START, i2cbw_pkg::ACT_STOP: begin
                w_starts = 1'b1;
            end
            i2cbw_pkg::ACT_BIT: begin
                w_shift = {i_in_item.data[0], 7'd0};
            end
            i2cbw_pkg::ACT_BYTE: begin
                w_grp_max = i2cbw_pkg::BYTE_GROUPS_M1;
            end
            i2cbw_pkg::ACT_PULSE: begin
                w_starts  = (w_count_sat != 5'd0);
                w_grp_max = w_count_sat - 5'd1;
            end
            default: begin
                w_starts = 1'b0;
            end
        endcase
    end

    // Sequencer state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2cbw_pkg::ST_IDLE: begin
                if (w_in_fire && w_starts) begin
                    n_state = i2cbw_pkg::ST_RUN;
                end
            end
            i2cbw_pkg::ST_RUN: begin
                if (w_load && w_change.last_change) begin
                    n_state = i2cbw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = i2cbw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2cbw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Phase and group counters with the bit shifter; a byte shifts in ones for the ack.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_action  <= i_in_item.action;
            r_delay   <= i_in_item.pulse_delay_ms;
            r_shift   <= w_shift;
            r_phase   <= '0;
            r_grp     <= '0;
            r_grp_max <= w_grp_max;
        end else if (w_load) begin
            if (r_phase == w_phase_max) begin
                r_phase <= '0;
                r_grp   <= r_grp + 5'd1;
                r_shift <= {r_shift[6:0], 1'b1};
            end else begin
                r_phase <= r_phase + 2'd1;
            end
        end
    end

    i2cbw_step_decode u_decode (
        .i_action    (r_action),
        .i_phase     (r_phase),
        .i_grp       (r_grp),
        .i_grp_max   (r_grp_max),
        .i_bit       (r_shift[7]),
        .i_delay     (r_delay),
        .o_change    (w_change),
        .o_phase_max (w_phase_max)
    );

    i2cbw_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_change    (w_change),
        .i_out_ready (i_out_ready),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_item)
    );

    // A command that makes no change leaves the sequencer idle.
    a_no_change_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !w_starts) |=> (r_state == i2cbw_pkg::ST_IDLE))
        else $error("sequencer left idle on a command without changes");

    // The final change of a command returns the sequencer to idle.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_change.last_change) |=> (r_state == i2cbw_pkg::ST_IDLE))
        else $error("sequencer kept running after the last change");

    // The phase counter never passes the last phase of the sequence.
    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2cbw_pkg::ST_RUN) |-> (r_phase <= w_phase_max))
        else $error("phase counter out of range");

    // The group counter never passes the last group of the command.
    a_grp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2cbw_pkg::ST_RUN) |-> (r_grp <= r_grp_max))
        else $error("group counter out of range");

endmodule

`default_nettype wire
